FILE: rtl/core/rgbf_pkg.sv
// Shared types, key codes and palette of the RGB sine fader.
`default_nettype none

package rgbf_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CH_CALC,
        ST_CH_ROM,
        ST_CH_MUL,
        ST_STEP_END,
        ST_FADE,
        ST_SCALE,
        ST_SCALE_W,
        ST_OUT
    } state_t;

    // Opcodes of an input word
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] REG_STEP_PERIOD = 8'd0;
    localparam logic [7:0] REG_COLOR_SPEED = 8'd1;

    // Remote key codes
    localparam logic [23:0] KEY_DIM    = 24'hF7807F;
    localparam logic [23:0] KEY_BRIGHT = 24'hF700FF;
    localparam logic [23:0] KEY_OFF    = 24'hF740BF;
    localparam logic [23:0] KEY_ON     = 24'hF7C03F;
    localparam logic [23:0] KEY_WHITE  = 24'hF7E01F;
    localparam logic [23:0] KEY_FASTER = 24'hF7D02F;
    localparam logic [23:0] KEY_SLOWER = 24'hF7F00F;
    localparam logic [23:0] KEY_FADE   = 24'hF7C837;

    // Palette size and the index that means no entry
    localparam int          PAL_SIZE = 15;
    localparam logic [3:0]  PAL_NONE = 4'd15;

    localparam logic [23:0] COL_WHITE = 24'hFFFFFF;
    localparam logic [23:0] COL_BLACK = 24'h000000;

    // Brightness and speed limits and steps
    localparam logic [7:0]  BRIGHT_MAX  = 8'd255;
    localparam logic [7:0]  BRIGHT_STEP = 8'd10;
    localparam logic [10:0] SPEED_MAX   = 11'd2000;
    localparam logic [10:0] SPEED_MIN   = 11'd100;
    localparam logic [10:0] SPEED_STEP  = 11'd50;
    // Reciprocal of 50 in Q0.16, exact for 11-bit speeds
    localparam logic [10:0] RECIP_50    = 11'd1311;

    localparam logic [23:0] PAL_KEYS [PAL_SIZE] = '{
        24'hF720DF, 24'hF7A05F, 24'hF7609F, 24'hF710EF, 24'hF7906F,
        24'hF750AF, 24'hF730CF, 24'hF7B04F, 24'hF7708F, 24'hF708F7,
        24'hF78877, 24'hF748B7, 24'hF728D7, 24'hF7A857, 24'hF76897};

    // Palette color as {red, green, blue}
    function automatic logic [23:0] pal_color(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = 24'hFF0000;
            4'd1:    c = 24'h00FF00;
            4'd2:    c = 24'h0000FF;
            4'd3:    c = 24'hFF3300;
            4'd4:    c = 24'h00FE64;
            4'd5:    c = 24'h3201FD;
            4'd6:    c = 24'hFE6700;
            4'd7:    c = 24'h00FFCA;
            4'd8:    c = 24'h6500FE;
            4'd9:    c = 24'hFE9900;
            4'd10:   c = 24'h00CCFD;
            4'd11:   c = 24'h9700FD;
            4'd12:   c = 24'hFFCC00;
            4'd13:   c = 24'h0099FD;
            4'd14:   c = 24'hCC00FF;
            default: c = COL_BLACK;
        endcase
        return c;
    endfunction

    // Palette entry of a color key, PAL_NONE when the code is no color key
    function automatic logic [3:0] key_index(input logic [23:0] code);
        logic [3:0] idx;
        idx = PAL_NONE;
        for (int i = 0; i < PAL_SIZE; i++) begin
            if (PAL_KEYS[i] == code) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgbf_sine_rom.sv
// Quarter-wave sine ROM in Q1.15 with registered read data.
`default_nettype none

module rgbf_sine_rom
    import rgbf_pkg::*;
#(
    parameter int QUARTER_STEPS = 1800
) (
    input  wire                                   aclk,
    input  wire  [$clog2(QUARTER_STEPS+1)-1:0]    addr,
    output logic [15:0]                           data
);

    typedef logic [15:0] tab_t [QUARTER_STEPS+1];

    // Polynomial sine of one table index, evaluated at elaboration
    function automatic logic [15:0] qsine(input int k);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] s;
        u  = (64'(k) << 30) / QUARTER_STEPS;
        u2 = (u * u) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995    - ((p * u2) >> 30);
        p  = 64'd85569306   - ((p * u2) >> 30);
        p  = 64'd693598668  - ((p * u2) >> 30);
        p  = 64'd1686629713 - ((p * u2) >> 30);
        s  = (p * u) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768) begin
            s = 64'd32768;
        end
        return s[15:0];
    endfunction

    function automatic tab_t build_tab();
        tab_t t;
        for (int k = 0; k <= QUARTER_STEPS; k++) begin
            t[k] = qsine(k);
        end
        return t;
    endfunction

    localparam tab_t SINE_TAB = build_tab();

    // Register the looked-up value
    always_ff @(posedge aclk) begin
        data <= SINE_TAB[addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/rgbf_mul.sv
// Shared 17x8 multiplier with registered product.
`default_nettype none

module rgbf_mul
    import rgbf_pkg::*;
(
    input  wire         aclk,
    input  wire  [16:0] mul_a,
    input  wire  [7:0]  mul_b,
    output logic [24:0] mul_p
);

    // Register the product for the next state
    always_ff @(posedge aclk) begin
        mul_p <= 25'(mul_a) * 25'(mul_b);
    end

endmodule

`default_nettype wire

FILE: rtl/core/ir_remote_rgb_sine_fader_unit.sv
// Top level of the remote-controlled RGB sine fader.
//
// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    opcode, ir_code, random_index
// m_       out        m_valid / m_ready    red/green/blue drive, lamp_on,
//                                          fade_active, changing
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A key word passes through the apply, fade, brightness scaling and output
// states, and the next word is taken once the sequencer is back in idle; a
// tick word that runs a transition step also passes each moving channel that
// does not reach its target through the sine ROM and the shared multiplier
// (calc, ROM and multiply states) before brightness scaling.
// s_ready is high only in the idle state; one word is in work at a time.
// A result waits in the output register while the next word is taken; the
// sequencer stalls at its last state while that register is still full.
// aresetn is synchronous, active low; cfg_ready is always high.
`default_nettype none

module ir_remote_rgb_sine_fader_unit
    import rgbf_pkg::*;
#(
    parameter int QUARTER_STEPS = 1800
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input words
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire  [23:0] s_ir_code,
    input  wire  [3:0]  s_random_index,
    // result words
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_red_drive,
    output logic [7:0]  m_green_drive,
    output logic [7:0]  m_blue_drive,
    output logic        m_lamp_on,
    output logic        m_fade_active,
    output logic        m_changing,
    // configuration writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_index,
    input  wire  [10:0] cfg_data
);

    localparam int PHW = $clog2(4*QUARTER_STEPS);
    localparam int ADW = $clog2(2*QUARTER_STEPS+1);
    localparam int RAW = $clog2(QUARTER_STEPS+1);

    localparam logic [PHW-1:0] PH_90   = PHW'(QUARTER_STEPS);
    localparam logic [PHW-1:0] PH_180  = PHW'(2*QUARTER_STEPS);
    localparam logic [PHW-1:0] PH_270  = PHW'(3*QUARTER_STEPS);
    localparam logic [PHW:0]   PH_FULL = (PHW+1)'(4*QUARTER_STEPS);
    localparam logic [ADW-1:0] ADV_MAX = ADW'(2*QUARTER_STEPS);

    // Sequencer and item registers
    state_t      state_reg, state_next;
    logic [1:0]  ch_reg, ch_next;
    logic        opcode_reg;
    logic [23:0] code_reg;
    logic [3:0]  ridx_reg;
    logic [5:0]  inc_reg, inc_next;
    logic        sign_reg, sign_next;

    // Lamp state
    logic [7:0]     level_reg   [3];
    logic [7:0]     level_next  [3];
    logic [7:0]     target_reg  [3];
    logic [7:0]     target_next [3];
    logic [7:0]     start_reg   [3];
    logic [7:0]     start_next  [3];
    logic [PHW-1:0] phase_reg   [3];
    logic [PHW-1:0] phase_next  [3];
    logic [ADW-1:0] advance_reg [3];
    logic [ADW-1:0] advance_next[3];
    logic [7:0]     drive_reg   [3];
    logic [7:0]     drive_next  [3];
    logic [7:0]     brightness_reg, brightness_next;
    logic [10:0]    fade_speed_reg, fade_speed_next;
    logic           on_reg, on_next;
    logic           fade_reg, fade_next;
    logic [7:0]     tick_reg, tick_next;
    logic [7:0]     step_period_reg, step_period_next;
    logic [10:0]    color_speed_reg, color_speed_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic        load_out;

    // Shared units
    logic [RAW-1:0] rom_addr;
    logic [15:0]    sin_q;
    logic [16:0]    mul_a;
    logic [7:0]     mul_b;
    logic [24:0]    mul_p;

    // Datapath helpers
    logic           changing;
    logic           last_ch;
    logic [7:0]     cur_level;
    logic [7:0]     cur_target;
    logic [7:0]     cur_start;
    logic [7:0]     lo;
    logic [7:0]     sw;
    logic [ADW:0]   adv_sum;
    logic [ADW-1:0] adv_new;
    logic [PHW:0]   ph_sum;
    logic [PHW-1:0] ph_new;
    logic [RAW-1:0] quad_idx;
    logic           quad_plus;
    logic [16:0]    frac;
    logic [10:0]    speed_sel;
    logic [21:0]    inc_prod;
    logic [7:0]     tick_inc;
    logic [7:0]     period;
    logic [3:0]     kidx;
    logic [16:0]    scale_sum;
    logic           do_set;
    logic [23:0]    new_col;
    logic [7:0]     col_ch [3];

    rgbf_sine_rom #(
        .QUARTER_STEPS(QUARTER_STEPS)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (sin_q)
    );

    rgbf_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // Channel under work and its transition arithmetic
    always_comb begin
        changing   = (target_reg[0] != level_reg[0]) || (target_reg[1] != level_reg[1])
                     || (target_reg[2] != level_reg[2]);
        last_ch    = (ch_reg == 2'd2);
        cur_level  = level_reg[ch_reg];
        cur_target = target_reg[ch_reg];
        cur_start  = start_reg[ch_reg];
        lo         = (cur_start < cur_target) ? cur_start : cur_target;
        sw         = (cur_start < cur_target) ? (cur_target - cur_start)
                                              : (cur_start - cur_target);
        adv_sum    = {1'b0, advance_reg[ch_reg]} + (ADW+1)'(inc_reg);
        adv_new    = (adv_sum > {1'b0, ADV_MAX}) ? ADV_MAX : adv_sum[ADW-1:0];
        ph_sum     = {1'b0, phase_reg[ch_reg]} + (PHW+1)'(inc_reg);
        ph_new     = (ph_sum >= PH_FULL) ? '0 : ph_sum[PHW-1:0];
        // Fold the phase into the quarter wave
        if (ph_new < PH_90) begin
            quad_idx  = RAW'(ph_new);
            quad_plus = 1'b1;
        end else if (ph_new < PH_180) begin
            quad_idx  = RAW'(PH_180 - ph_new);
            quad_plus = 1'b1;
        end else if (ph_new < PH_270) begin
            quad_idx  = RAW'(ph_new - PH_180);
            quad_plus = 1'b0;
        end else begin
            quad_idx  = RAW'(PHW'(4*QUARTER_STEPS) - ph_new);
            quad_plus = 1'b0;
        end
        frac      = sign_reg ? (17'd32768 + 17'(sin_q)) : (17'd32768 - 17'(sin_q));
        speed_sel = fade_reg ? fade_speed_reg : color_speed_reg;
        inc_prod  = 22'(speed_sel) * 22'(RECIP_50);
        tick_inc  = tick_reg + 8'd1;
        period    = (step_period_reg == 8'd0) ? 8'd1 : step_period_reg;
        kidx      = key_index(code_reg);
        // Divide by 255 for products below 2^16
        scale_sum = 17'(mul_p[15:0]) + 17'(mul_p[15:8]) + 17'd1;
    end

    // Next state and datapath control
    always_comb begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        inc_next         = inc_reg;
        sign_next        = sign_reg;
        level_next       = level_reg;
        target_next      = target_reg;
        start_next       = start_reg;
        phase_next       = phase_reg;
        advance_next     = advance_reg;
        drive_next       = drive_reg;
        brightness_next  = brightness_reg;
        fade_speed_next  = fade_speed_reg;
        on_next          = on_reg;
        fade_next        = fade_reg;
        tick_next        = tick_reg;
        step_period_next = step_period_reg;
        color_speed_next = color_speed_reg;
        m_valid_next     = m_valid_reg;
        load_out         = 1'b0;
        do_set           = 1'b0;
        new_col          = COL_BLACK;
        rom_addr         = quad_idx;
        mul_a            = '0;
        mul_b            = '0;
        s_ready          = (state_reg == ST_IDLE);
        cfg_ready        = 1'b1;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_STEP_PERIOD: step_period_next = cfg_data[7:0];
                REG_COLOR_SPEED: color_speed_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                inc_next = (inc_prod[21:16] == 6'd0) ? 6'd1 : inc_prod[21:16];
                state_next = ST_FADE;
                if (opcode_reg == OP_KEY) begin
                    case (code_reg)
                        KEY_ON: begin
                            on_next   = 1'b1;
                            fade_next = 1'b0;
                            do_set    = 1'b1;
                            new_col   = COL_WHITE;
                        end
                        KEY_OFF: begin
                            fade_next = 1'b0;
                            do_set    = 1'b1;
                            new_col   = COL_BLACK;
                        end
                        KEY_DIM: begin
                            brightness_next = (brightness_reg > BRIGHT_STEP)
                                              ? (brightness_reg - BRIGHT_STEP) : 8'd0;
                        end
                        KEY_BRIGHT: begin
                            brightness_next = (9'(brightness_reg) + 9'(BRIGHT_STEP)
                                               >= 9'(BRIGHT_MAX))
                                              ? BRIGHT_MAX : (brightness_reg + BRIGHT_STEP);
                        end
                        KEY_WHITE: begin
                            fade_next = 1'b0;
                            do_set    = 1'b1;
                            new_col   = COL_WHITE;
                        end
                        KEY_FASTER: begin
                            fade_speed_next = (12'(fade_speed_reg) + 12'(SPEED_STEP)
                                               >= 12'(SPEED_MAX))
                                              ? SPEED_MAX : (fade_speed_reg + SPEED_STEP);
                        end
                        KEY_SLOWER: begin
                            fade_speed_next = (fade_speed_reg <= 11'd150)
                                              ? SPEED_MIN : (fade_speed_reg - SPEED_STEP);
                        end
                        KEY_FADE: begin
                            if (on_reg) begin
                                fade_next = !fade_reg;
                            end
                        end
                        default: begin
                            if (kidx != PAL_NONE) begin
                                fade_next = 1'b0;
                                do_set    = 1'b1;
                                new_col   = pal_color(kidx);
                            end
                        end
                    endcase
                end else begin
                    // Count the tick and start a step when the period is up and the lamp is on
                    if (tick_inc >= period) begin
                        tick_next = 8'd0;
                        if (on_reg) begin
                            ch_next    = 2'd0;
                            state_next = ST_CH_CALC;
                        end
                    end else begin
                        tick_next = tick_inc;
                    end
                end
            end
            ST_CH_CALC: begin
                if (cur_target != cur_level) begin
                    advance_next[ch_reg] = adv_new;
                    phase_next[ch_reg]   = ph_new;
                    if (adv_new == ADV_MAX) begin
                        level_next[ch_reg] = cur_target;
                        ch_next    = last_ch ? ch_reg : ch_reg + 2'd1;
                        state_next = last_ch ? ST_STEP_END : ST_CH_CALC;
                    end else begin
                        sign_next  = quad_plus;
                        state_next = ST_CH_ROM;
                    end
                end else begin
                    phase_next[ch_reg] = PH_90;
                    ch_next    = last_ch ? ch_reg : ch_reg + 2'd1;
                    state_next = last_ch ? ST_STEP_END : ST_CH_CALC;
                end
            end
            ST_CH_ROM: begin
                mul_a      = frac;
                mul_b      = sw;
                state_next = ST_CH_MUL;
            end
            ST_CH_MUL: begin
                level_next[ch_reg] = lo + mul_p[23:16];
                ch_next    = last_ch ? ch_reg : ch_reg + 2'd1;
                state_next = last_ch ? ST_STEP_END : ST_CH_CALC;
            end
            ST_STEP_END: begin
                on_next = (level_reg[0] != 8'd0) || (level_reg[1] != 8'd0)
                          || (level_reg[2] != 8'd0) || (target_reg[0] != 8'd0)
                          || (target_reg[1] != 8'd0) || (target_reg[2] != 8'd0);
                state_next = ST_FADE;
            end
            ST_FADE: begin
                if (fade_reg && !changing && (ridx_reg != PAL_NONE)) begin
                    do_set  = 1'b1;
                    new_col = pal_color(ridx_reg);
                end
                ch_next    = 2'd0;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                mul_a      = 17'(level_reg[ch_reg]);
                mul_b      = brightness_reg;
                state_next = ST_SCALE_W;
            end
            ST_SCALE_W: begin
                drive_next[ch_reg] = scale_sum[15:8];
                ch_next    = last_ch ? ch_reg : ch_reg + 2'd1;
                state_next = last_ch ? ST_OUT : ST_SCALE;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Retarget all channels when the color changes
        col_ch[0] = new_col[23:16];
        col_ch[1] = new_col[15:8];
        col_ch[2] = new_col[7:0];
        if (do_set && ({target_reg[0], target_reg[1], target_reg[2]} != new_col)) begin
            for (int i = 0; i < 3; i++) begin
                target_next[i]  = col_ch[i];
                start_next[i]   = level_reg[i];
                advance_next[i] = '0;
                phase_next[i]   = (col_ch[i] < level_reg[i]) ? PH_90 : PH_270;
            end
        end
    end

    // Control and lamp state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ch_reg          <= 2'd0;
            inc_reg         <= 6'd1;
            sign_reg        <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                level_reg[i]   <= 8'd0;
                target_reg[i]  <= 8'd0;
                start_reg[i]   <= 8'd0;
                phase_reg[i]   <= PH_270;
                advance_reg[i] <= '0;
            end
            brightness_reg  <= BRIGHT_MAX;
            fade_speed_reg  <= 11'd300;
            on_reg          <= 1'b0;
            fade_reg        <= 1'b0;
            tick_reg        <= 8'd0;
            step_period_reg <= 8'd5;
            color_speed_reg <= 11'd300;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ch_reg          <= ch_next;
            inc_reg         <= inc_next;
            sign_reg        <= sign_next;
            level_reg       <= level_next;
            target_reg      <= target_next;
            start_reg       <= start_next;
            phase_reg       <= phase_next;
            advance_reg     <= advance_next;
            brightness_reg  <= brightness_next;
            fade_speed_reg  <= fade_speed_next;
            on_reg          <= on_next;
            fade_reg        <= fade_next;
            tick_reg        <= tick_next;
            step_period_reg <= step_period_next;
            color_speed_reg <= color_speed_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        drive_reg <= drive_next;
        if (s_valid && s_ready) begin
            opcode_reg <= s_opcode;
            code_reg   <= s_ir_code;
            ridx_reg   <= s_random_index;
        end
        if (load_out) begin
            m_red_drive   <= drive_reg[0];
            m_green_drive <= drive_reg[1];
            m_blue_drive  <= drive_reg[2];
            m_lamp_on     <= on_reg;
            m_fade_active <= fade_reg;
            m_changing    <= changing;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rgbf_checker.sv
// Port-level checks of the RGB sine fader, bound to the top level.
`default_nettype none

module rgbf_checker
    import rgbf_pkg::*;
(
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [7:0]  m_red_drive,
    input wire [7:0]  m_green_drive,
    input wire [7:0]  m_blue_drive,
    input wire        m_lamp_on
);

    // A held result stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // One word in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    // A dark lamp drives nothing
    a_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_lamp_on |-> (m_red_drive == 8'd0) && (m_green_drive == 8'd0)
                                  && (m_blue_drive == 8'd0))
        else $error("drive while lamp is off");

    // Results leave only after a word was taken
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready || $past(!s_ready))
        else $error("result without input word");

endmodule

bind ir_remote_rgb_sine_fader_unit rgbf_checker u_rgbf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_red_drive   (m_red_drive),
    .m_green_drive (m_green_drive),
    .m_blue_drive  (m_blue_drive),
    .m_lamp_on     (m_lamp_on)
);

`default_nettype wire
